[src/rau_pkg.sv]
// rau_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
  localparam int unsigned DataWidthDef = 32;

  typedef enum logic [1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DivOpQuot = 2'd0,
    DivOpRem  = 2'd1
  } div_op_e;

  typedef enum logic [4:0] {
    StIdle,
    StPrep,
    StMulP,
    StGcdRem,
    StGcdWait,
    StLcmDiv,
    StLcmWait,
    StWa,
    StWaWait,
    StWb,
    StWbWait,
    StMulA,
    StMulB,
    StFin,
    StRedRem,
    StRedWait,
    StRedN,
    StRedNWait,
    StRedD,
    StRedDWait,
    StOut
  } state_e;
endpackage

[src/rau_if.sv]
// rau_in_if / rau_out_if: valid-ready channels of the rational arithmetic unit
// depends on: nothing
interface rau_in_if #(parameter int unsigned DataWidth = 32);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic signed [DataWidth-1:0] a_num;
  logic signed [DataWidth-1:0] a_den;
  logic signed [DataWidth-1:0] b_num;
  logic signed [DataWidth-1:0] b_den;
  logic                        reduce;
  modport source (output valid, cmd, a_num, a_den, b_num, b_den, reduce, input ready);
  modport sink (input valid, cmd, a_num, a_den, b_num, b_den, reduce, output ready);
endinterface

interface rau_out_if #(parameter int unsigned DataWidth = 32);
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] res_num;
  logic signed [DataWidth-1:0] res_den;
  logic                        div_error;
  modport source (output valid, res_num, res_den, div_error, input ready);
  modport sink (input valid, res_num, res_den, div_error, output ready);
endinterface

[src/rau_div.sv]
// rau_div: radix-2 signed divider, truncating, one quotient bit per cycle
// depends on: rau_pkg
module rau_div
  import rau_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DataWidth-1:0] a_i,
  input  logic [DataWidth-1:0] b_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] quot_o,
  output logic [DataWidth-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(DataWidth + 1);

  logic [DataWidth-1:0] b_q, b_d, r_q, r_d, qb_q, qb_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic                 na_q, na_d, nq_q, nq_d, bz_q, bz_d;
  logic [DataWidth:0]   trial;
  logic [DataWidth-1:0] a_orig_q, a_orig_d;

  always_comb begin
    b_d = b_q; r_d = r_q; qb_d = qb_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; na_d = na_q; nq_d = nq_q; bz_d = bz_q;
    a_orig_d = a_orig_q;
    trial = {r_q, qb_q[DataWidth-1]} - {1'b0, b_q};
    if (start_i) begin
      a_orig_d = a_i;
      na_d  = a_i[DataWidth-1];
      nq_d  = a_i[DataWidth-1] ^ b_i[DataWidth-1];
      bz_d  = (b_i == '0);
      qb_d  = a_i[DataWidth-1] ? -a_i : a_i;
      b_d   = b_i[DataWidth-1] ? -b_i : b_i;
      r_d   = '0;
      cnt_d = CntW'(DataWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DataWidth]) begin
        r_d  = trial[DataWidth-1:0];
        qb_d = {qb_q[DataWidth-2:0], 1'b1};
      end else begin
        r_d  = {r_q[DataWidth-2:0], qb_q[DataWidth-1]};
        qb_d = {qb_q[DataWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d; r_q <= r_d; qb_q <= qb_d;
    na_q <= na_d; nq_q <= nq_d; bz_q <= bz_d; a_orig_q <= a_orig_d;
  end

  assign done_o = done_q;
  assign quot_o = bz_q ? '0 : (nq_q ? -qb_q : qb_q);
  assign rem_o  = bz_q ? a_orig_q : (na_q ? -r_q : r_q);

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
`endif
endmodule

[src/rational_arithmetic_unit_top.sv]
// rational_arithmetic_unit_top: fraction add/sub/mul/div with optional gcd reduction
// work runs as divisions on the shared radix-2 divider (euclid steps, lcm, scaling, reduction);
// output stalls delay the result valid; on error (zero divisor) the divider is not used
// throughput: one item at a time, ready again the cycle after the result is registered
// reset: rst_ni asynchronous active low clears the sequencer and the output valid
// depends on: rau_pkg, rau_if, rau_div
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);
  typedef logic [DataWidth-1:0] w_t;

  state_e st_q, st_d;
  w_t an_q, ad_q, bn_q, bd_q, x_q, y_q, g_q, w_q, n_q, d_q, p_q, t_q;
  w_t an_d, ad_d, bn_d, bd_d, x_d, y_d, g_d, w_d, n_d, d_d, p_d, t_d;
  logic red_q, red_d, err_q, err_d, ov_q, ov_d;
  cmd_e cmd_q, cmd_d;
  logic dstart;
  w_t da, db, dq, dr;
  logic ddone;
  w_t prod;
  w_t ma, mb;

  rau_div #(.DataWidth(DataWidth)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .a_i(da), .b_i(db),
    .done_o(ddone), .quot_o(dq), .rem_o(dr)
  );

  assign prod = ma * mb;

  always_comb begin
    st_d = st_q; an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    x_d = x_q; y_d = y_q; g_d = g_q; w_d = w_q; n_d = n_q; d_d = d_q;
    p_d = p_q; t_d = t_q; red_d = red_q; err_d = err_q; ov_d = ov_q; cmd_d = cmd_q;
    dstart = 1'b0; da = x_q; db = y_q; ma = ad_q; mb = bd_q;
    unique case (st_q)
      StIdle: if (in_i.valid) begin
        cmd_d = cmd_e'(in_i.cmd);
        an_d = in_i.a_num; ad_d = in_i.a_den; bd_d = in_i.b_den;
        bn_d = (cmd_e'(in_i.cmd) == CmdSub) ? -in_i.b_num : in_i.b_num;
        red_d = in_i.reduce; err_d = 1'b0;
        st_d = StPrep;
      end
      StPrep: begin
        if (cmd_q == CmdAdd || cmd_q == CmdSub) begin
          x_d = ad_q; y_d = bd_q; st_d = StMulP;
        end else if (cmd_q == CmdMul) begin
          ma = an_q; mb = bn_q; n_d = prod[DataWidth-1:0];
          st_d = StMulA;
        end else if (bn_q == '0 || bd_q == '0) begin
          n_d = '0; d_d = '0; err_d = 1'b1; st_d = StOut;
        end else begin
          ma = an_q; mb = bd_q; n_d = prod[DataWidth-1:0];
          st_d = StMulB;
        end
      end
      StMulA: begin
        ma = ad_q; mb = bd_q; d_d = prod[DataWidth-1:0]; st_d = StFin;
      end
      StMulB: begin
        ma = ad_q; mb = bn_q; d_d = prod[DataWidth-1:0]; st_d = StFin;
      end
      StMulP: begin
        p_d = prod[DataWidth-1:0];
        if (ad_q == bd_q) begin
          n_d = an_q + bn_q; d_d = ad_q; st_d = StFin;
        end else begin
          dstart = 1'b1; st_d = StGcdWait;
        end
      end
      StGcdWait: if (ddone) begin
        if (dr == '0) begin
          g_d = y_q; dstart = 1'b1; da = p_q; db = y_q; st_d = StLcmWait;
        end else begin
          x_d = y_q; y_d = dr; dstart = 1'b1; da = y_q; db = dr;
        end
      end
      StLcmWait: if (ddone) begin
        w_d = dq; dstart = 1'b1; da = dq; db = ad_q; st_d = StWaWait;
      end
      StWaWait: if (ddone) begin
        ma = an_q; mb = dq; t_d = prod[DataWidth-1:0];
        dstart = 1'b1; da = w_q; db = bd_q; st_d = StWbWait;
      end
      StWbWait: if (ddone) begin
        ma = bn_q; mb = dq; n_d = t_q + prod[DataWidth-1:0]; d_d = w_q;
        st_d = StFin;
      end
      StFin: begin
        if (red_q) begin
          x_d = n_q; y_d = d_q; dstart = 1'b1; da = n_q; db = d_q;
          st_d = StRedWait;
        end else st_d = StOut;
      end
      StRedWait: if (ddone) begin
        if (dr == '0) begin
          g_d = y_q; dstart = 1'b1; da = n_q; db = y_q; st_d = StRedNWait;
        end else begin
          x_d = y_q; y_d = dr; dstart = 1'b1; da = y_q; db = dr;
        end
      end
      StRedNWait: if (ddone) begin
        n_d = dq; dstart = 1'b1; da = d_q; db = g_q; st_d = StRedDWait;
      end
      StRedDWait: if (ddone) begin
        d_d = dq; st_d = StOut;
      end
      StOut: if (!ov_q || out_o.ready) begin
        ov_d = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
    if (ov_q && out_o.ready && st_q != StOut) ov_d = 1'b0;
  end

  logic [DataWidth-1:0] rn_q, rd_q;
  logic re_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    x_q <= x_d; y_q <= y_d; g_q <= g_d; w_q <= w_d; n_q <= n_d; d_q <= d_d;
    p_q <= p_d; t_q <= t_d; red_q <= red_d; err_q <= err_d; cmd_q <= cmd_d;
    if (st_q == StOut && (!ov_q || out_o.ready)) begin
      rn_q <= n_q; rd_q <= d_q; re_q <= err_q;
    end
  end

  assign in_i.ready      = (st_q == StIdle);
  assign out_o.valid     = ov_q;
  assign out_o.res_num   = rn_q;
  assign out_o.res_den   = rd_q;
  assign out_o.div_error = re_q;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> st_q == StIdle) else $error("ready outside idle");
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> st_q == StPrep) else $error("accept lost");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.div_error) |-> out_o.res_den == '0) else $error("err den");
`endif
endmodule
